// File: src/ibd_pkg.sv
// Shared types, constants and the control program for the idle backlight dimmer.
// No dependencies; imported by the sequencer, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ibd_pkg;

	// Field widths
	localparam int LevelW   = 7;
	localparam int TimeW    = 20;
	localparam int ElapsedW = 16;
	localparam int CmdW     = 3;
	localparam int CfgIdxW  = 2;
	localparam int PcW      = 4;

	// Shared multiplier: 18 x 20 operands, 38-bit product
	localparam int MulAW    = 18;
	localparam int MulBW    = 20;
	localparam int ProdW    = MulAW + MulBW;

	localparam logic [LevelW-1:0]  MaxLevel     = 7'd100;
	localparam logic [LevelW-1:0]  ResetLevel   = 7'd100;
	localparam logic [TimeW-1:0]   ResetTimeout = 20'd60000;
	localparam logic [LevelW-1:0]  ResetRatio   = 7'd15;
	localparam logic [LevelW-1:0]  ResetFloor   = 7'd4;

	// x / 100 = (x * 10486) >> 20, exact for x below 2^14
	localparam logic [MulBW-1:0]   Recip100     = 20'd10486;
	localparam int                 Shift100     = 20;
	// y / 25 = (y * 671089) >> 24, exact for y below 2^18; 800 = 32 * 25
	localparam logic [MulBW-1:0]   Recip25      = 20'd671089;
	localparam int                 Shift25      = 24;
	localparam int                 Shift32      = 5;

	// Command codes
	localparam logic [CmdW-1:0] CMD_INIT  = 3'd0;
	localparam logic [CmdW-1:0] CMD_SETU  = 3'd1;
	localparam logic [CmdW-1:0] CMD_WAKE  = 3'd2;
	localparam logic [CmdW-1:0] CMD_ATTN  = 3'd3;
	localparam logic [CmdW-1:0] CMD_TICK  = 3'd4;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_RATIO   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_FLOOR   = 2'd2;

	typedef logic [PcW-1:0] pc_t;

	// Program entry points and fixed addresses
	localparam pc_t PC_INIT   = 4'd0;
	localparam pc_t PC_SETU   = 4'd1;
	localparam pc_t PC_WAKE   = 4'd2;
	localparam pc_t PC_ATTN   = 4'd3;
	localparam pc_t PC_ATTN_W = 4'd4;
	localparam pc_t PC_TICK   = 4'd5;
	localparam pc_t PC_MUL_T  = 4'd6;
	localparam pc_t PC_DIV_T  = 4'd7;
	localparam pc_t PC_TGT    = 4'd8;
	localparam pc_t PC_SPAN   = 4'd9;
	localparam pc_t PC_MUL_S  = 4'd10;
	localparam pc_t PC_DIV_S  = 4'd11;
	localparam pc_t PC_FADE   = 4'd12;
	localparam pc_t PC_SHOWU  = 4'd13;
	localparam pc_t PC_END    = 4'd14;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_INIT,
		OP_SETU,
		OP_WAKE,
		OP_ATTN,
		OP_IDLE,
		OP_SHOWU,
		OP_MUL_T,
		OP_DIV_T,
		OP_TGT,
		OP_SPAN,
		OP_MUL_S,
		OP_DIV_S,
		OP_FADE
	} op_t;

	typedef enum logic [1:0] {
		CN_NONE,
		CN_NO_RISE,
		CN_NO_FADE,
		CN_NO_STEP
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
		logic  fin;
	} cword_t;

	// Sequencer to datapath
	typedef struct packed {
		logic capture;
		op_t  op;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic hold;
		logic rise;
		logic no_fade;
		logic no_step;
	} stat_t;

	typedef enum logic {
		SQ_IDLE,
		SQ_RUN
	} seq_state_t;

	// Control store: one word per step
	function automatic cword_t ibd_rom(input pc_t pc);
		cword_t w;
		w = '{op: OP_NOP, cond: CN_NONE, target: PC_END, fin: 1'b1};
		case (pc)
			PC_INIT:   w = '{op: OP_INIT,  cond: CN_NONE,    target: PC_END,   fin: 1'b1};
			PC_SETU:   w = '{op: OP_SETU,  cond: CN_NONE,    target: PC_END,   fin: 1'b0};
			PC_WAKE:   w = '{op: OP_WAKE,  cond: CN_NONE,    target: PC_END,   fin: 1'b1};
			PC_ATTN:   w = '{op: OP_ATTN,  cond: CN_NO_RISE, target: PC_END,   fin: 1'b0};
			PC_ATTN_W: w = '{op: OP_WAKE,  cond: CN_NONE,    target: PC_END,   fin: 1'b1};
			PC_TICK:   w = '{op: OP_IDLE,  cond: CN_NO_FADE, target: PC_SHOWU, fin: 1'b0};
			PC_MUL_T:  w = '{op: OP_MUL_T, cond: CN_NONE,    target: PC_END,   fin: 1'b0};
			PC_DIV_T:  w = '{op: OP_DIV_T, cond: CN_NONE,    target: PC_END,   fin: 1'b0};
			PC_TGT:    w = '{op: OP_TGT,   cond: CN_NONE,    target: PC_END,   fin: 1'b0};
			PC_SPAN:   w = '{op: OP_SPAN,  cond: CN_NO_STEP, target: PC_END,   fin: 1'b0};
			PC_MUL_S:  w = '{op: OP_MUL_S, cond: CN_NONE,    target: PC_END,   fin: 1'b0};
			PC_DIV_S:  w = '{op: OP_DIV_S, cond: CN_NONE,    target: PC_END,   fin: 1'b0};
			PC_FADE:   w = '{op: OP_FADE,  cond: CN_NONE,    target: PC_END,   fin: 1'b1};
			PC_SHOWU:  w = '{op: OP_SHOWU, cond: CN_NONE,    target: PC_END,   fin: 1'b1};
			default:   w = '{op: OP_NOP,   cond: CN_NONE,    target: PC_END,   fin: 1'b1};
		endcase
		return w;
	endfunction

	// Map a command to the first step of its routine
	function automatic pc_t ibd_entry(input logic [CmdW-1:0] cmd);
		pc_t pc;
		pc = PC_END;
		case (cmd)
			CMD_INIT: pc = PC_INIT;
			CMD_SETU: pc = PC_SETU;
			CMD_WAKE: pc = PC_WAKE;
			CMD_ATTN: pc = PC_ATTN;
			CMD_TICK: pc = PC_TICK;
			default:  pc = PC_END;
		endcase
		return pc;
	endfunction

endpackage

`default_nettype wire

// File: src/idle_backlight_dimmer.sv
// Idle backlight dimmer, top level: ibd_seq steps a microprogram over ibd_dp.
// Each accepted command runs its program to the end before the next is taken (item_stall
// is high while busy); a showing step waits while the result register is full and stalled.
// All multiplies and divides share one 18x20 multiplier.
// Reset clears state to user and shown level 100, idle count 0, defaults set.
`timescale 1ns / 1ps
`default_nettype none

module idle_backlight_dimmer
	import ibd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire logic [CmdW-1:0]     cmd,
	input  wire logic [LevelW-1:0]   level,
	input  wire logic                attn_req,
	input  wire logic [ElapsedW-1:0] tick_ms,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic [LevelW-1:0]        backlight_percent,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [TimeW-1:0]    cfg_data
);

	ctrl_t ctrl;
	stat_t stat;
	logic  busy;

	// Sequencer
	ibd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.cmd        (cmd),
		.stat       (stat),
		.ctrl       (ctrl),
		.busy       (busy)
	);

	// Datapath
	ibd_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.level             (level),
		.attn_req          (attn_req),
		.tick_ms           (tick_ms),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.result_stall      (result_stall),
		.result_valid      (result_valid),
		.backlight_percent (backlight_percent),
		.stat              (stat)
	);

	assign item_stall = busy;
	assign cfg_ready  = !busy;

	// An accepted beat starts a program
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("sequencer did not start after an accepted beat");

	// Shown level never exceeds full scale
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> backlight_percent <= MaxLevel)
		else $error("result level above full scale");

	// A new result only comes from a running program
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result raised while sequencer idle");

	// The sequencer holds only while the result register is full and stalled
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hold |-> result_valid && result_stall)
		else $error("sequencer held without a stalled result");

endmodule

`default_nettype wire

// File: src/ibd_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on ibd_pkg for the control word, the program and the status types.
`timescale 1ns / 1ps
`default_nettype none

module ibd_seq
	import ibd_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	input  wire logic [CmdW-1:0] cmd,
	input  wire stat_t           stat,
	output ctrl_t                ctrl,
	output logic                 busy
);

	seq_state_t state_q, state_nx;
	pc_t        pc_q, pc_nx;
	cword_t     cw;
	logic       jump;

	// Hold state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			pc_q    <= PC_END;
		end else begin
			state_q <= state_nx;
			pc_q    <= pc_nx;
		end
	end

	// Decode the current word and pick the next step
	always_comb begin
		cw           = ibd_rom(pc_q);
		state_nx     = state_q;
		pc_nx        = pc_q;
		ctrl.capture = 1'b0;
		ctrl.op      = OP_NOP;
		busy         = 1'b1;
		case (cw.cond)
			CN_NO_RISE: jump = !stat.rise;
			CN_NO_FADE: jump = stat.no_fade;
			CN_NO_STEP: jump = stat.no_step;
			default:    jump = 1'b0;
		endcase
		case (state_q)
			SQ_IDLE: begin
				busy         = 1'b0;
				ctrl.capture = item_valid;
				if (item_valid) begin
					state_nx = SQ_RUN;
					pc_nx    = ibd_entry(cmd);
				end
			end
			SQ_RUN: begin
				ctrl.op = cw.op;
				if (!stat.hold) begin
					if (cw.fin) begin
						state_nx = SQ_IDLE;
					end else if (jump) begin
						pc_nx = cw.target;
					end else begin
						pc_nx = pc_q + 1'b1;
					end
				end
			end
			default: begin
				state_nx = SQ_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/ibd_dp.sv
// Datapath: settings, dimmer state, shared multiplier and the result register.
// Depends on ibd_pkg; driven step by step by ibd_seq.
`timescale 1ns / 1ps
`default_nettype none

module ibd_dp
	import ibd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctrl_t               ctrl,
	input  wire logic [LevelW-1:0]   level,
	input  wire logic                attn_req,
	input  wire logic [ElapsedW-1:0] tick_ms,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [TimeW-1:0]    cfg_data,
	input  wire logic                result_stall,
	output logic                     result_valid,
	output logic [LevelW-1:0]        backlight_percent,
	output stat_t                    stat
);

	// Settings and state
	logic [TimeW-1:0]    timeout_q;
	logic [LevelW-1:0]   ratio_q, floor_q;
	logic [LevelW-1:0]   user_q, shown_q;
	logic [TimeW-1:0]    idle_q;
	logic                seen_q;
	logic                out_valid_q;
	// Captured beat and scratch
	logic [LevelW-1:0]   lvl_q;
	logic                np_q;
	logic [ElapsedW-1:0] elapsed_q;
	logic [LevelW-1:0]   tgt_q, span_q, out_level_q;
	logic [ProdW-1:0]    prod_q;

	logic [LevelW-1:0]   lvl_clamp;
	logic [TimeW:0]      idle_sum;
	logic                idle_lt, idle_sat;
	logic [TimeW-1:0]    idle_nx;
	logic [MulAW-1:0]    mul_a;
	logic [MulBW-1:0]    mul_b;
	logic [ProdW-1:0]    prod_nx;
	logic [LevelW-1:0]   quot_t, tgt_fl, tgt_nx;
	logic [13:0]         step_raw, step;
	logic [LevelW-1:0]   diff, fade_lvl, show_lvl;
	logic                show_op, out_free, emit;

	assign lvl_clamp = (level > MaxLevel) ? MaxLevel : level;

	// Idle counter update and tick path choice
	always_comb begin
		idle_lt  = idle_q < timeout_q;
		idle_sum = {1'b0, idle_q} + {{(TimeW + 1 - ElapsedW){1'b0}}, elapsed_q};
		idle_sat = idle_sum >= {1'b0, timeout_q};
		idle_nx  = idle_sat ? timeout_q : idle_sum[TimeW-1:0];
	end

	// Shared multiplier operand select
	always_comb begin
		case (ctrl.op)
			OP_MUL_T: begin
				mul_a = {{(MulAW - LevelW){1'b0}}, user_q};
				mul_b = {{(MulBW - LevelW){1'b0}}, ratio_q};
			end
			OP_DIV_T: begin
				mul_a = {4'b0, prod_q[13:0]};
				mul_b = Recip100;
			end
			OP_MUL_S: begin
				mul_a = {{(MulAW - LevelW){1'b0}}, span_q};
				mul_b = {{(MulBW - ElapsedW){1'b0}}, elapsed_q};
			end
			default: begin
				mul_a = prod_q[Shift32 +: MulAW];
				mul_b = Recip25;
			end
		endcase
		prod_nx = {{MulBW{1'b0}}, mul_a} * {{MulAW{1'b0}}, mul_b};
	end

	// Dim target: quotient raised to the floor, capped at the user level
	always_comb begin
		quot_t = prod_q[Shift100 +: LevelW];
		tgt_fl = (quot_t < floor_q) ? floor_q : quot_t;
		tgt_nx = (tgt_fl > user_q) ? user_q : tgt_fl;
	end

	// Fade step and the level to show
	always_comb begin
		step_raw = prod_q[Shift25 +: 14];
		step     = (step_raw == 14'd0) ? 14'd1 : step_raw;
		diff     = shown_q - tgt_q;
		fade_lvl = (step >= {7'b0, diff}) ? tgt_q : shown_q - step[LevelW-1:0];
		show_lvl = (ctrl.op == OP_FADE) ? fade_lvl : user_q;
	end

	// Status to the sequencer: hold a showing step while the result register is full and stalled
	always_comb begin
		show_op      = (ctrl.op == OP_WAKE) || (ctrl.op == OP_SHOWU) || (ctrl.op == OP_FADE);
		out_free     = !out_valid_q || !result_stall;
		stat.hold    = show_op && !out_free;
		stat.rise    = np_q && !seen_q;
		stat.no_fade = idle_lt && !idle_sat;
		stat.no_step = (shown_q <= tgt_q) || (user_q <= tgt_q);
		emit         = show_op && out_free && (show_lvl != shown_q);
	end

	// Advance state and settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= ResetTimeout;
			ratio_q     <= ResetRatio;
			floor_q     <= ResetFloor;
			user_q      <= ResetLevel;
			shown_q     <= ResetLevel;
			idle_q      <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_RATIO:   ratio_q   <= cfg_data[LevelW-1:0];
					REG_FLOOR:   floor_q   <= cfg_data[LevelW-1:0];
					default:     ;
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (ctrl.op)
				OP_INIT: begin
					user_q  <= lvl_q;
					shown_q <= lvl_q;
					idle_q  <= '0;
				end
				OP_SETU: begin
					user_q <= lvl_q;
				end
				OP_WAKE: begin
					if (!stat.hold) begin
						idle_q  <= '0;
						shown_q <= show_lvl;
					end
				end
				OP_SHOWU, OP_FADE: begin
					if (!stat.hold) begin
						shown_q <= show_lvl;
					end
				end
				OP_ATTN: begin
					seen_q <= np_q;
				end
				OP_IDLE: begin
					if (idle_lt) begin
						idle_q <= idle_nx;
					end
				end
				default: ;
			endcase
		end
	end

	// Capture the beat, scratch registers and result payload
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			lvl_q     <= lvl_clamp;
			np_q      <= attn_req;
			elapsed_q <= tick_ms;
		end
		case (ctrl.op)
			OP_MUL_T, OP_DIV_T, OP_MUL_S, OP_DIV_S: prod_q <= prod_nx;
			OP_TGT:  tgt_q  <= tgt_nx;
			OP_SPAN: span_q <= user_q - tgt_q;
			default: ;
		endcase
		if (emit) begin
			out_level_q <= show_lvl;
		end
	end

	assign result_valid      = out_valid_q;
	assign backlight_percent = out_level_q;

endmodule

`default_nettype wire
